@@ hdl/pove_pkg.sv @@
// Shared types and constants for the priority override table.
// No dependencies; every other file imports this package.
package pove_pkg;

  localparam logic [31:0] FOREVER = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CMD_REQUEST = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_RESOLVE = 2'd2
  } cmd_t;

  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_RESOLVE = 1'b1
  } op_kind_t;

  // stamp is the expiry for a write and the tick snapshot for a resolve
  typedef struct packed {
    op_kind_t    kind;
    logic [2:0]  tgt;
    logic [2:0]  src;
    logic [15:0] value;
    logic [31:0] stamp;
  } op_t;

endpackage

@@ hdl/pove_front.sv @@
// Front end: accepts commands, owns the tick counter, turns requests and
// resolves into queue ops. Depends on pove_pkg.
module pove_front import pove_pkg::*; #(
  parameter int OUTPUT_COUNT = 8,
  parameter int SOURCE_COUNT = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        stall,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [2:0]  target_output,
  input  logic [2:0]  source_level,
  input  logic [15:0] request_value,
  input  logic [31:0] duration,
  output logic        push,
  output op_t         push_op
);

  logic [31:0] tick;
  logic        accept;
  logic        in_range;

  assign busy     = stall;
  assign accept   = start && !stall;
  assign in_range = ({29'd0, target_output} < 32'(OUTPUT_COUNT)) &&
                    ({29'd0, source_level} < 32'(SOURCE_COUNT));

  always_comb begin
    push          = 1'b0;
    push_op.kind  = OP_WRITE;
    push_op.tgt   = target_output;
    push_op.src   = source_level;
    push_op.value = request_value;
    push_op.stamp = (duration == FOREVER) ? FOREVER : tick + duration;
    case (cmd_t'(command))
      CMD_REQUEST: begin
        push = accept && in_range;
      end
      CMD_RESOLVE: begin
        push          = accept;
        push_op.kind  = OP_RESOLVE;
        push_op.stamp = tick;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick <= '0;
    end else if (accept && (cmd_t'(command) == CMD_TICK)) begin
      tick <= tick + 32'd1;
    end
  end

endmodule

@@ hdl/pove_queue.sv @@
// Two-entry op queue between the front end and the table engine.
// Depends on pove_pkg.
module pove_queue import pove_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  input  logic pop,
  output op_t  head,
  output logic empty,
  output logic full
);

  op_t        slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head  = slots[rd_ptr];
  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hdl/pove_back.sv @@
// Table engine: holds the value/expiry table, clears it after reset,
// applies writes and sweeps outputs for a resolve. Depends on pove_pkg.
module pove_back import pove_pkg::*; #(
  parameter int OUTPUT_COUNT = 8,
  parameter int SOURCE_COUNT = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  op_t         head,
  input  logic        empty,
  output logic        pop,
  output logic        clearing,
  output logic        strobe,
  output logic [2:0]  result_output,
  output logic [15:0] result_value,
  output logic        last_of_run
);

  localparam int ROW_W = (OUTPUT_COUNT > 1) ? $clog2(OUTPUT_COUNT) : 1;
  localparam int COL_W = (SOURCE_COUNT > 1) ? $clog2(SOURCE_COUNT) : 1;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(OUTPUT_COUNT - 1);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_SWEEP = 3'b100
  } state_t;

  state_t                  state;
  logic [ROW_W-1:0]        row;
  logic [31:0]             sweep_stamp;

  logic [15:0]             mem_value  [OUTPUT_COUNT][SOURCE_COUNT];
  logic [31:0]             mem_expiry [OUTPUT_COUNT][SOURCE_COUNT];

  logic                    wr_en;
  logic [ROW_W-1:0]        wr_row;
  logic [SOURCE_COUNT-1:0] wr_mask;
  logic [15:0]             wr_value;
  logic [31:0]             wr_expiry;
  logic                    rd_en;
  logic [COL_W-1:0]        wr_col;

  logic [15:0]             rd_value  [SOURCE_COUNT];
  logic [31:0]             rd_expiry [SOURCE_COUNT];
  logic                    rd_valid;
  logic [ROW_W-1:0]        rd_row;
  logic [31:0]             rd_stamp;
  logic [15:0]             win;

  assign clearing = (state == ST_CLEAR);
  assign pop      = (state == ST_IDLE) && !empty;
  assign rd_en    = (state == ST_SWEEP);
  assign wr_col   = COL_W'(head.src);

  always_comb begin
    wr_en     = 1'b0;
    wr_row    = ROW_W'(head.tgt);
    wr_mask   = '0;
    wr_value  = head.value;
    wr_expiry = head.stamp;
    if (state == ST_CLEAR) begin
      wr_en     = 1'b1;
      wr_row    = row;
      wr_mask   = '1;
      wr_value  = '0;
      wr_expiry = '0;
    end else if (pop && (head.kind == OP_WRITE)) begin
      wr_en           = 1'b1;
      wr_mask[wr_col] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int c = 0; c < SOURCE_COUNT; c++) begin
        if (wr_mask[c]) begin
          mem_value[wr_row][c]  <= wr_value;
          mem_expiry[wr_row][c] <= wr_expiry;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_value  <= mem_value[row];
      rd_expiry <= mem_expiry[row];
      rd_row    <= row;
      rd_stamp  <= sweep_stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      row         <= '0;
      sweep_stamp <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (row == LAST_ROW) begin
            row   <= '0;
            state <= ST_IDLE;
          end else begin
            row <= row + 1'b1;
          end
        end
        ST_IDLE: begin
          if (pop && (head.kind == OP_RESOLVE)) begin
            sweep_stamp <= head.stamp;
            row         <= '0;
            state       <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          if (row == LAST_ROW) begin
            row   <= '0;
            state <= ST_IDLE;
          end else begin
            row <= row + 1'b1;
          end
        end
        default: begin
          row   <= '0;
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  // highest live source wins
  always_comb begin
    win = '0;
    for (int s = 0; s < SOURCE_COUNT; s++) begin
      if ((rd_expiry[s] == FOREVER) || (rd_stamp <= rd_expiry[s])) begin
        win = rd_value[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      rd_valid <= rd_en;
      strobe   <= rd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      result_output <= 3'(rd_row);
      result_value  <= win;
      last_of_run   <= (rd_row == LAST_ROW);
    end
  end

endmodule

@@ hdl/priority_override_with_expiry.sv @@
// Priority override table with expiry: front end, op queue, table engine; uses pove_pkg.
// A resolve holds the table engine while it sweeps the outputs, one row read per cycle;
// busy is high while the queue is full. Results strobe one per cycle after the sweep reads
// are registered; results cannot be stalled. After reset busy stays high while the table
// is cleared one row per cycle.
module priority_override_with_expiry import pove_pkg::*; #(
  parameter int OUTPUT_COUNT = 8,
  parameter int SOURCE_COUNT = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [2:0]  target_output,
  input  logic [2:0]  source_level,
  input  logic [15:0] request_value,
  input  logic [31:0] duration,
  output logic        strobe,
  output logic [2:0]  result_output,
  output logic [15:0] result_value,
  output logic        last_of_run
);

  logic push;
  op_t  push_op;
  logic pop;
  op_t  head;
  logic empty;
  logic full;
  logic clearing;

  pove_front #(
    .OUTPUT_COUNT(OUTPUT_COUNT),
    .SOURCE_COUNT(SOURCE_COUNT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .stall        (full || clearing),
    .busy         (busy),
    .command      (command),
    .target_output(target_output),
    .source_level (source_level),
    .request_value(request_value),
    .duration     (duration),
    .push         (push),
    .push_op      (push_op)
  );

  pove_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .push_op(push_op),
    .pop    (pop),
    .head   (head),
    .empty  (empty),
    .full   (full)
  );

  pove_back #(
    .OUTPUT_COUNT(OUTPUT_COUNT),
    .SOURCE_COUNT(SOURCE_COUNT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .clearing     (clearing),
    .strobe       (strobe),
    .result_output(result_output),
    .result_value (result_value),
    .last_of_run  (last_of_run)
  );

endmodule
